FILE: rtl/core/rls_pkg.sv
// Shared types, register codes and reset values for the reflectance line steering block.
// No dependencies; used by rls_decide and reflectance_line_steering.
package rls_pkg;

   // fixed field widths
   localparam int SENSOR_BITS    = 8;
   localparam int MODE_BITS      = 3;
   localparam int WIN_BITS       = 14;
   localparam int THR_BITS       = 14;
   localparam int SPEED_BITS     = 12;
   localparam int ACTION_BITS    = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 14;

   // channels that the steering rules look at (channel 1 to channel 8)
   localparam int RULE_CHANNELS  = 8;

   // parameter defaults
   localparam int DEF_CHANNELS   = 8;
   localparam int DEF_TIME_BITS  = 14;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_SECTION_MODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CRUISE_SPEED   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW_SPEED     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PIVOT_SPEED    = 3'd6;

   // register reset values
   localparam logic [MODE_BITS-1:0]  RST_SECTION_MODE   = 3'd0;
   localparam logic [WIN_BITS-1:0]   RST_WINDOW_LENGTH  = 14'd10000;
   localparam logic [THR_BITS-1:0]   RST_LOW_THRESHOLD  = 14'd200;
   localparam logic [THR_BITS-1:0]   RST_HIGH_THRESHOLD = 14'd800;
   localparam logic [SPEED_BITS-1:0] RST_CRUISE_SPEED   = 12'd2300;
   localparam logic [SPEED_BITS-1:0] RST_SLOW_SPEED     = 12'd2100;
   localparam logic [SPEED_BITS-1:0] RST_PIVOT_SPEED    = 12'd1000;

   // section modes
   localparam logic [MODE_BITS-1:0] MODE_RIGHT_PIVOT = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_RIGHT_PLAIN = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_STOP_WHITE  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_LAP_MARK    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_CROSSING    = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_LEFT_PIVOT  = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_LEFT_PLAIN  = 3'd6;

   // steering actions
   localparam logic [ACTION_BITS-1:0] ACT_CRUISE      = 4'd0;
   localparam logic [ACTION_BITS-1:0] ACT_VEER_LEFT   = 4'd1;
   localparam logic [ACTION_BITS-1:0] ACT_VEER_RIGHT  = 4'd2;
   localparam logic [ACTION_BITS-1:0] ACT_PIVOT_RIGHT = 4'd3;
   localparam logic [ACTION_BITS-1:0] ACT_PIVOT_LEFT  = 4'd4;
   localparam logic [ACTION_BITS-1:0] ACT_EXIT_RIGHT  = 4'd5;
   localparam logic [ACTION_BITS-1:0] ACT_EXIT_LEFT   = 4'd6;
   localparam logic [ACTION_BITS-1:0] ACT_EXIT_FWD    = 4'd7;
   localparam logic [ACTION_BITS-1:0] ACT_EXIT_STOP   = 4'd8;

   // decision settings handed to the rule logic
   typedef struct packed {
      logic [MODE_BITS-1:0]  section_mode;
      logic [THR_BITS-1:0]   low_threshold;
      logic [THR_BITS-1:0]   high_threshold;
      logic [SPEED_BITS-1:0] cruise_speed;
      logic [SPEED_BITS-1:0] slow_speed;
      logic [SPEED_BITS-1:0] pivot_speed;
   } rls_cfg_type;

   // one steering decision
   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [SPEED_BITS-1:0]  left_drive;
      logic [SPEED_BITS-1:0]  right_drive;
      logic                   left_reverse;
      logic                   right_reverse;
      logic                   section_done;
   } rls_result_type;

endpackage

FILE: rtl/core/rls_decide.sv
// Steering rules: turns the per-channel capture times of one window into a decision.
// Depends on rls_pkg for the settings and decision structs and the action codes.
module rls_decide #(
   parameter int CHANNELS  = rls_pkg::DEF_CHANNELS,
   parameter int TIME_BITS = rls_pkg::DEF_TIME_BITS
) (
   input  rls_pkg::rls_cfg_type    cfg,
   input  logic [TIME_BITS-1:0]    chan_time [CHANNELS],
   output rls_pkg::rls_result_type decision
);

   localparam int CMP_BITS = (TIME_BITS > rls_pkg::THR_BITS) ? TIME_BITS : rls_pkg::THR_BITS;

   logic [CMP_BITS-1:0] rule_time [rls_pkg::RULE_CHANNELS];
   logic [CMP_BITS-1:0] low_ext;
   logic [CMP_BITS-1:0] high_ext;
   logic [rls_pkg::RULE_CHANNELS-1:0] seen;
   logic [rls_pkg::RULE_CHANNELS-1:0] hit;
   logic [rls_pkg::RULE_CHANNELS-1:0] dark;
   rls_pkg::rls_result_type veer_res;
   rls_pkg::rls_result_type pivot_r_res;
   rls_pkg::rls_result_type pivot_l_res;

   function automatic rls_pkg::rls_result_type make_res(
      input logic [rls_pkg::ACTION_BITS-1:0] act,
      input logic [rls_pkg::SPEED_BITS-1:0]  ls,
      input logic [rls_pkg::SPEED_BITS-1:0]  rs,
      input logic                            lr,
      input logic                            rr,
      input logic                            done
   );
      rls_pkg::rls_result_type res;
      res.action        = act;
      res.left_drive    = ls;
      res.right_drive   = rs;
      res.left_reverse  = lr;
      res.right_reverse = rr;
      res.section_done  = done;
      return res;
   endfunction

   assign low_ext  = CMP_BITS'(cfg.low_threshold);
   assign high_ext = CMP_BITS'(cfg.high_threshold);

   // widen the rule channels; a channel the port lacks reads as time zero
   for (genvar k = 0; k < rls_pkg::RULE_CHANNELS; k++) begin : g_rule
      if (k < CHANNELS) begin : g_have
         assign rule_time[k] = CMP_BITS'(chan_time[k]);
      end else begin : g_none
         assign rule_time[k] = '0;
      end
      assign seen[k] = rule_time[k] > low_ext;
      assign hit[k]  = seen[k] && (rule_time[k] < high_ext);
      assign dark[k] = rule_time[k] < low_ext;
   end

   // fallback veer rules: channel 3 steers left, channel 6 steers right
   always_comb begin
      if (hit[2]) begin
         veer_res = make_res(rls_pkg::ACT_VEER_LEFT, cfg.slow_speed, cfg.cruise_speed,
                             1'b0, 1'b0, 1'b0);
      end else if (hit[5]) begin
         veer_res = make_res(rls_pkg::ACT_VEER_RIGHT, cfg.cruise_speed, cfg.slow_speed,
                             1'b0, 1'b0, 1'b0);
      end else begin
         veer_res = make_res(rls_pkg::ACT_CRUISE, cfg.cruise_speed, cfg.cruise_speed,
                             1'b0, 1'b0, 1'b0);
      end
   end

   assign pivot_r_res = make_res(rls_pkg::ACT_PIVOT_RIGHT, cfg.pivot_speed, cfg.pivot_speed,
                                 1'b0, 1'b1, 1'b0);
   assign pivot_l_res = make_res(rls_pkg::ACT_PIVOT_LEFT, cfg.pivot_speed, cfg.pivot_speed,
                                 1'b1, 1'b0, 1'b0);

   // priority rules per section mode
   always_comb begin
      decision = veer_res;
      case (cfg.section_mode)
         rls_pkg::MODE_RIGHT_PIVOT: begin
            if (hit[0]) begin
               decision = make_res(rls_pkg::ACT_EXIT_RIGHT, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end else if (hit[1]) begin
               decision = pivot_r_res;
            end else if (hit[6]) begin
               decision = pivot_l_res;
            end
         end
         rls_pkg::MODE_RIGHT_PLAIN: begin
            if (hit[0]) begin
               decision = make_res(rls_pkg::ACT_EXIT_RIGHT, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end
         end
         rls_pkg::MODE_STOP_WHITE: begin
            if (dark[3] && dark[4]) begin
               decision = make_res(rls_pkg::ACT_EXIT_STOP, '0, '0, 1'b0, 1'b0, 1'b1);
            end
         end
         rls_pkg::MODE_LAP_MARK: begin
            if (seen[3] && seen[4] && (seen[2] || seen[5])) begin
               decision = make_res(rls_pkg::ACT_EXIT_FWD, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end
         end
         rls_pkg::MODE_CROSSING: begin
            if (seen[0] || seen[7]) begin
               decision = make_res(rls_pkg::ACT_EXIT_FWD, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end else if (hit[6]) begin
               decision = pivot_l_res;
            end else if (hit[1]) begin
               decision = pivot_r_res;
            end
         end
         rls_pkg::MODE_LEFT_PIVOT: begin
            if (hit[7]) begin
               decision = make_res(rls_pkg::ACT_EXIT_LEFT, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end else if (hit[6]) begin
               decision = pivot_l_res;
            end else if (hit[1]) begin
               decision = pivot_r_res;
            end
         end
         rls_pkg::MODE_LEFT_PLAIN: begin
            if (hit[7]) begin
               decision = make_res(rls_pkg::ACT_EXIT_LEFT, cfg.cruise_speed,
                                   cfg.cruise_speed, 1'b0, 1'b0, 1'b1);
            end
         end
         default: begin
            decision = veer_res;
         end
      endcase
   end

endmodule

FILE: rtl/core/reflectance_line_steering.sv
// Top level of the reflectance line steering block: poll counter, capture times,
// settings registers and the result register. Depends on rls_pkg and rls_decide.
//
// Usage:
//   req_* carries one poll of the sensor port per word (req_sensor_bits, bit i is
//   channel i+1, 0 means discharged). A word is taken when req_valid is high and
//   req_stall is low. One word can be taken every cycle.
//   Each channel records the poll index of its first discharged reading in the
//   window. The last poll of a window (window_length polls, counter restarting at
//   zero) produces one decision word on rsp_*, registered, so it appears in the
//   cycle after that poll is taken. Other polls produce no word.
//   rsp_valid holds with a steady payload while rsp_stall is high. Polls keep
//   flowing during a stall; req_stall rises only when the next poll would end a
//   window while the previous decision is still held.
//   csr_* writes the settings (index 0 section mode, 1 window length, 2 low
//   threshold, 3 high threshold, 4 cruise, 5 slow, 6 pivot speed); csr_ready is
//   always high and unknown indexes are ignored. Write only while idle.
//   Reset (synchronous, active high) restores the default settings, clears the
//   counter and the capture times and empties the result register. No clearing
//   pass is needed; the block takes polls in the cycle after reset.
module reflectance_line_steering #(
   parameter int CHANNELS  = rls_pkg::DEF_CHANNELS,
   parameter int TIME_BITS = rls_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // poll channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rls_pkg::SENSOR_BITS-1:0]     req_sensor_bits,
   // decision channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rls_pkg::ACTION_BITS-1:0]     rsp_action,
   output logic [rls_pkg::SPEED_BITS-1:0]      rsp_left_drive,
   output logic [rls_pkg::SPEED_BITS-1:0]      rsp_right_drive,
   output logic                                rsp_left_reverse,
   output logic                                rsp_right_reverse,
   output logic                                rsp_section_done,
   // settings write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rls_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rls_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CNT_CMP_BITS = (TIME_BITS > rls_pkg::WIN_BITS) ? TIME_BITS : rls_pkg::WIN_BITS;

   // settings
   rls_pkg::rls_cfg_type             cfg_ff;
   logic [rls_pkg::WIN_BITS-1:0]     window_length_ff;

   // window state
   logic [TIME_BITS-1:0]             poll_counter_ff;
   logic [TIME_BITS-1:0]             poll_counter_in;
   logic [TIME_BITS-1:0]             first_low_ff [CHANNELS];
   logic [TIME_BITS-1:0]             cap_time     [CHANNELS];

   // result register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   rls_pkg::rls_result_type          rsp_data_ff;
   rls_pkg::rls_result_type          decision;

   logic                             req_accept;
   logic                             window_end;
   logic                             rsp_free;

   // settings writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.section_mode   <= rls_pkg::RST_SECTION_MODE;
         cfg_ff.low_threshold  <= rls_pkg::RST_LOW_THRESHOLD;
         cfg_ff.high_threshold <= rls_pkg::RST_HIGH_THRESHOLD;
         cfg_ff.cruise_speed   <= rls_pkg::RST_CRUISE_SPEED;
         cfg_ff.slow_speed     <= rls_pkg::RST_SLOW_SPEED;
         cfg_ff.pivot_speed    <= rls_pkg::RST_PIVOT_SPEED;
         window_length_ff      <= rls_pkg::RST_WINDOW_LENGTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rls_pkg::REG_SECTION_MODE: begin
               cfg_ff.section_mode <= csr_data[rls_pkg::MODE_BITS-1:0];
            end
            rls_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_data[rls_pkg::WIN_BITS-1:0];
            end
            rls_pkg::REG_LOW_THRESHOLD: begin
               cfg_ff.low_threshold <= csr_data[rls_pkg::THR_BITS-1:0];
            end
            rls_pkg::REG_HIGH_THRESHOLD: begin
               cfg_ff.high_threshold <= csr_data[rls_pkg::THR_BITS-1:0];
            end
            rls_pkg::REG_CRUISE_SPEED: begin
               cfg_ff.cruise_speed <= csr_data[rls_pkg::SPEED_BITS-1:0];
            end
            rls_pkg::REG_SLOW_SPEED: begin
               cfg_ff.slow_speed <= csr_data[rls_pkg::SPEED_BITS-1:0];
            end
            rls_pkg::REG_PIVOT_SPEED: begin
               cfg_ff.pivot_speed <= csr_data[rls_pkg::SPEED_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // window end: next count reaches the length, or wraps to zero
   assign poll_counter_in = poll_counter_ff + TIME_BITS'(1);
   assign window_end = (CNT_CMP_BITS'(poll_counter_in) >= CNT_CMP_BITS'(window_length_ff))
                    || (poll_counter_in == '0);

   // hold polls only when a window would end into a held decision
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = window_end && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // capture first discharge per channel; channels past the port read discharged
   for (genvar c = 0; c < CHANNELS; c++) begin : g_cap
      logic low_bit;
      if (c < rls_pkg::SENSOR_BITS) begin : g_port
         assign low_bit = !req_sensor_bits[c];
      end else begin : g_none
         assign low_bit = 1'b1;
      end
      assign cap_time[c] = ((first_low_ff[c] == '0) && low_bit) ? poll_counter_ff
                                                                : first_low_ff[c];
   end

   // advance the window on each accepted poll
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_counter_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            first_low_ff[c] <= '0;
         end
      end else if (req_accept) begin
         if (window_end) begin
            poll_counter_ff <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
               first_low_ff[c] <= '0;
            end
         end else begin
            poll_counter_ff <= poll_counter_in;
            for (int c = 0; c < CHANNELS; c++) begin
               first_low_ff[c] <= cap_time[c];
            end
         end
      end
   end

   // decide from this poll's capture times
   rls_decide #(
      .CHANNELS  (CHANNELS),
      .TIME_BITS (TIME_BITS)
   ) u_decide (
      .cfg       (cfg_ff),
      .chan_time (cap_time),
      .decision  (decision)
   );

   // result register: load on a window end, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && window_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && window_end) begin
         rsp_data_ff <= decision;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_data_ff.action;
   assign rsp_left_drive    = rsp_data_ff.left_drive;
   assign rsp_right_drive   = rsp_data_ff.right_drive;
   assign rsp_left_reverse  = rsp_data_ff.left_reverse;
   assign rsp_right_reverse = rsp_data_ff.right_reverse;
   assign rsp_section_done  = rsp_data_ff.section_done;

   // a poll that closes a window always leaves a decision behind
   a_window_gives_word: assert property (@(posedge clock) disable iff (reset)
      (req_accept && window_end) |=> rsp_valid_ff)
      else $error("window end produced no decision");

   // section_done marks exactly the exit actions
   a_done_matches_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.section_done ==
         ((rsp_data_ff.action == rls_pkg::ACT_EXIT_RIGHT)
       || (rsp_data_ff.action == rls_pkg::ACT_EXIT_LEFT)
       || (rsp_data_ff.action == rls_pkg::ACT_EXIT_FWD)
       || (rsp_data_ff.action == rls_pkg::ACT_EXIT_STOP))))
      else $error("section_done disagrees with action");

   // a pivot reverses exactly one wheel, nothing else reverses any
   a_pivot_reverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.left_reverse || rsp_data_ff.right_reverse) ==
         ((rsp_data_ff.action == rls_pkg::ACT_PIVOT_RIGHT)
       || (rsp_data_ff.action == rls_pkg::ACT_PIVOT_LEFT))))
      else $error("wheel reverse bits disagree with action");

   // a poll taken mid-window moves the counter on by one
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !window_end) |=> (poll_counter_ff == $past(poll_counter_in)))
      else $error("poll counter did not advance");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for reflectance_line_steering: polls the sensor port,
// predicts each window's steering decision and checks every decision word.
// Depends on rls_pkg and the reflectance_line_steering RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_BITS = rls_pkg::CSR_DATA_BITS;
   localparam logic [rls_pkg::CSR_INDEX_BITS-1:0] REG_SPARE = 3'd7;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_POLLS  = 1170;
   localparam int CALM_POLLS    = 150;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [rls_pkg::SENSOR_BITS-1:0]    req_sensor_bits = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [rls_pkg::ACTION_BITS-1:0]    rsp_action;
   logic [rls_pkg::SPEED_BITS-1:0]     rsp_left_drive;
   logic [rls_pkg::SPEED_BITS-1:0]     rsp_right_drive;
   logic                               rsp_left_reverse;
   logic                               rsp_right_reverse;
   logic                               rsp_section_done;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [rls_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [DATA_BITS-1:0]               csr_data = '0;

   // predicted settings and capture state
   logic [rls_pkg::MODE_BITS-1:0]  cfg_mode;
   logic [rls_pkg::WIN_BITS-1:0]   cfg_window;
   logic [rls_pkg::THR_BITS-1:0]   cfg_low;
   logic [rls_pkg::THR_BITS-1:0]   cfg_high;
   logic [rls_pkg::SPEED_BITS-1:0] cfg_cruise;
   logic [rls_pkg::SPEED_BITS-1:0] cfg_slow;
   logic [rls_pkg::SPEED_BITS-1:0] cfg_pivot;
   logic [rls_pkg::WIN_BITS-1:0]   poll_count;
   logic [rls_pkg::WIN_BITS-1:0]   first_low [rls_pkg::RULE_CHANNELS];

   logic [rls_pkg::SENSOR_BITS-1:0] poll_queue [$];
   rls_pkg::rls_result_type         decisions_due [$];
   rls_pkg::rls_result_type         due_word;

   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_orders = 0;
   int hold_served = 0;
   int mismatch_count = 0;
   int decisions_checked = 0;
   bit calm = 1'b0;

   // poll generator: mirrors the window position of the polls queued so far
   int gen_pos = 0;
   int gen_plan [rls_pkg::RULE_CHANNELS];
   bit gen_noise = 1'b1;

   reflectance_line_steering dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_bits   (req_sensor_bits),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_section_done  (rsp_section_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- decision rules

   function automatic rls_pkg::rls_result_type make_word(
      input logic [rls_pkg::ACTION_BITS-1:0] act,
      input logic [rls_pkg::SPEED_BITS-1:0] ls,
      input logic [rls_pkg::SPEED_BITS-1:0] rs,
      input logic lr, input logic rr,
      input logic done);
      rls_pkg::rls_result_type w;
      w.action        = act;
      w.left_drive    = ls;
      w.right_drive   = rs;
      w.left_reverse  = lr;
      w.right_reverse = rr;
      w.section_done  = done;
      return w;
   endfunction

   function automatic logic chan_seen(input int n);
      return first_low[n-1] > cfg_low;
   endfunction

   function automatic logic chan_hit(input int n);
      return first_low[n-1] > cfg_low && first_low[n-1] < cfg_high;
   endfunction

   function automatic rls_pkg::rls_result_type exit_word(
      input logic [rls_pkg::ACTION_BITS-1:0] act);
      return make_word(act, cfg_cruise, cfg_cruise, 1'b0, 1'b0, 1'b1);
   endfunction

   function automatic rls_pkg::rls_result_type veer_word();
      if (chan_hit(3))
         return make_word(rls_pkg::ACT_VEER_LEFT, cfg_slow, cfg_cruise, 1'b0, 1'b0, 1'b0);
      if (chan_hit(6))
         return make_word(rls_pkg::ACT_VEER_RIGHT, cfg_cruise, cfg_slow, 1'b0, 1'b0, 1'b0);
      return make_word(rls_pkg::ACT_CRUISE, cfg_cruise, cfg_cruise, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic rls_pkg::rls_result_type steer_decide();
      rls_pkg::rls_result_type turn_right;
      rls_pkg::rls_result_type turn_left;
      turn_right = make_word(rls_pkg::ACT_PIVOT_RIGHT, cfg_pivot, cfg_pivot,
                             1'b0, 1'b1, 1'b0);
      turn_left  = make_word(rls_pkg::ACT_PIVOT_LEFT, cfg_pivot, cfg_pivot,
                             1'b1, 1'b0, 1'b0);
      case (cfg_mode)
         rls_pkg::MODE_RIGHT_PIVOT: begin
            if (chan_hit(1)) return exit_word(rls_pkg::ACT_EXIT_RIGHT);
            if (chan_hit(2)) return turn_right;
            if (chan_hit(7)) return turn_left;
         end
         rls_pkg::MODE_RIGHT_PLAIN: begin
            if (chan_hit(1)) return exit_word(rls_pkg::ACT_EXIT_RIGHT);
         end
         rls_pkg::MODE_STOP_WHITE: begin
            if (first_low[3] < cfg_low && first_low[4] < cfg_low)
               return make_word(rls_pkg::ACT_EXIT_STOP, '0, '0, 1'b0, 1'b0, 1'b1);
         end
         rls_pkg::MODE_LAP_MARK: begin
            if (chan_seen(4) && chan_seen(5) && (chan_seen(3) || chan_seen(6)))
               return exit_word(rls_pkg::ACT_EXIT_FWD);
         end
         rls_pkg::MODE_CROSSING: begin
            if (chan_seen(1) || chan_seen(8)) return exit_word(rls_pkg::ACT_EXIT_FWD);
            if (chan_hit(7)) return turn_left;
            if (chan_hit(2)) return turn_right;
         end
         rls_pkg::MODE_LEFT_PIVOT: begin
            if (chan_hit(8)) return exit_word(rls_pkg::ACT_EXIT_LEFT);
            if (chan_hit(7)) return turn_left;
            if (chan_hit(2)) return turn_right;
         end
         rls_pkg::MODE_LEFT_PLAIN: begin
            if (chan_hit(8)) return exit_word(rls_pkg::ACT_EXIT_LEFT);
         end
         default: ;
      endcase
      return veer_word();
   endfunction

   // capture first discharge times; close the window once the count reaches its length
   task automatic steer_step(input logic [rls_pkg::SENSOR_BITS-1:0] bits);
      logic [rls_pkg::WIN_BITS-1:0] next_count;
      for (int c = 0; c < rls_pkg::RULE_CHANNELS; c++)
         if (first_low[c] == '0 && !bits[c])
            first_low[c] = poll_count;
      next_count = poll_count + 1'b1;
      if (next_count >= cfg_window || next_count == '0) begin
         decisions_due.push_back(steer_decide());
         poll_count = '0;
         for (int c = 0; c < rls_pkg::RULE_CHANNELS; c++)
            first_low[c] = '0;
      end else begin
         poll_count = next_count;
      end
   endtask

   // ---------------------------------------------------------------- settings port

   task automatic csr_write(input logic [rls_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      // keep only the width of each register, drop unknown indexes
      case (idx)
         rls_pkg::REG_SECTION_MODE:   cfg_mode   = data[rls_pkg::MODE_BITS-1:0];
         rls_pkg::REG_WINDOW_LENGTH:  cfg_window = data[rls_pkg::WIN_BITS-1:0];
         rls_pkg::REG_LOW_THRESHOLD:  cfg_low    = data[rls_pkg::THR_BITS-1:0];
         rls_pkg::REG_HIGH_THRESHOLD: cfg_high   = data[rls_pkg::THR_BITS-1:0];
         rls_pkg::REG_CRUISE_SPEED:   cfg_cruise = data[rls_pkg::SPEED_BITS-1:0];
         rls_pkg::REG_SLOW_SPEED:     cfg_slow   = data[rls_pkg::SPEED_BITS-1:0];
         rls_pkg::REG_PIVOT_SPEED:    cfg_pivot  = data[rls_pkg::SPEED_BITS-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [DATA_BITS-1:0] speed_data();
      logic [DATA_BITS-1:0] data;
      int r;
      data = DATA_BITS'($urandom_range(0, 16383));
      r = $urandom_range(0, 9);
      if (r == 0)
         data[rls_pkg::SPEED_BITS-1:0] = '0;
      else if (r == 1)
         data[rls_pkg::SPEED_BITS-1:0] = '1;
      return data;
   endfunction

   // pick a fresh setting; windows stay short so that decisions come often
   task automatic random_settings();
      logic [DATA_BITS-1:0] data;
      int span;
      int r;
      if ($urandom_range(0, 3) != 0) begin
         data = DATA_BITS'($urandom_range(0, 16383));
         csr_write(rls_pkg::REG_SECTION_MODE, data);
      end
      r = $urandom_range(0, 19);
      if (r == 0)
         data = '0;
      else if (r == 1)
         data = DATA_BITS'(1);
      else
         data = DATA_BITS'($urandom_range(2, 24));
      csr_write(rls_pkg::REG_WINDOW_LENGTH, data);
      span = (cfg_window == '0) ? 1 : int'(cfg_window);
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 15);
         if (r == 0)
            data = '0;
         else if (r == 1)
            data = '1;
         else
            data = DATA_BITS'($urandom_range(0, span));
         csr_write(rls_pkg::REG_LOW_THRESHOLD, data);
      end
      if ($urandom_range(0, 3) != 0) begin
         r = $urandom_range(0, 15);
         if (r == 0)
            data = '1;
         else if (r == 1)
            data = '0;
         else
            data = DATA_BITS'($urandom_range(0, span + 2));
         csr_write(rls_pkg::REG_HIGH_THRESHOLD, data);
      end
      if ($urandom_range(0, 3) != 0) csr_write(rls_pkg::REG_CRUISE_SPEED, speed_data());
      if ($urandom_range(0, 3) != 0) csr_write(rls_pkg::REG_SLOW_SPEED, speed_data());
      if ($urandom_range(0, 3) != 0) csr_write(rls_pkg::REG_PIVOT_SPEED, speed_data());
      if ($urandom_range(0, 3) == 0) begin
         data = DATA_BITS'($urandom_range(0, 16383));
         csr_write(REG_SPARE, data);
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- poll generation

   // choose per channel the poll index of its first discharge, near the thresholds
   task automatic plan_window();
      int span;
      int d;
      span = (cfg_window == '0) ? 1 : int'(cfg_window);
      gen_noise = ($urandom_range(0, 7) == 0);
      for (int c = 0; c < rls_pkg::RULE_CHANNELS; c++) begin
         case ($urandom_range(0, 6))
            0:       d = 0;
            1:       d = int'(cfg_low);
            2:       d = int'(cfg_low) + 1;
            3:       d = int'(cfg_high) - 1;
            4:       d = int'(cfg_high);
            5:       d = $urandom_range(0, span - 1);
            default: d = span;
         endcase
         gen_plan[c] = d;
      end
   endtask

   task automatic queue_poll(input logic [rls_pkg::SENSOR_BITS-1:0] bits);
      int next;
      poll_queue.push_back(bits);
      next = gen_pos + 1;
      gen_pos = (next >= int'(cfg_window)) ? 0 : next;
   endtask

   task automatic queue_windowed(input int count);
      logic [rls_pkg::SENSOR_BITS-1:0] bits;
      repeat (count) begin
         if (gen_pos == 0) plan_window();
         for (int c = 0; c < rls_pkg::RULE_CHANNELS; c++) begin
            if (gen_noise || gen_pos > gen_plan[c])
               bits[c] = 1'($urandom_range(0, 1));
            else
               bits[c] = (gen_pos < gen_plan[c]);
         end
         queue_poll(bits);
      end
   endtask

   // hold until every poll is taken and every decision word has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (poll_queue.size() != 0 || req_valid || decisions_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------- driver

   // offer the next poll word once the held one is taken, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) steer_step(req_sensor_bits);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (poll_queue.size() != 0) begin
               req_valid       <= 1'b1;
               req_sensor_bits <= poll_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // compare each decision word with the oldest one due, then drive the stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decisions_due.size() == 0) begin
               $error("decision word with none due: action %0d", rsp_action);
               mismatch_count++;
            end else begin
               due_word = decisions_due.pop_front();
               check_field("action", int'(due_word.action), int'(rsp_action));
               check_field("left_drive", int'(due_word.left_drive), int'(rsp_left_drive));
               check_field("right_drive", int'(due_word.right_drive),
                           int'(rsp_right_drive));
               check_field("left_reverse", int'(due_word.left_reverse),
                           int'(rsp_left_reverse));
               check_field("right_reverse", int'(due_word.right_reverse),
                           int'(rsp_right_reverse));
               check_field("section_done", int'(due_word.section_done),
                           int'(rsp_section_done));
               decisions_checked++;
            end
         end
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [rls_pkg::SENSOR_BITS-1:0] pivot_polls [5];
      int random_polls;
      int span;
      int count;
      pivot_polls = '{8'hFE, 8'hFD, 8'hBF, 8'hFB, 8'hDF};
      random_polls = 0;
      cfg_mode   = rls_pkg::RST_SECTION_MODE;
      cfg_window = rls_pkg::RST_WINDOW_LENGTH;
      cfg_low    = rls_pkg::RST_LOW_THRESHOLD;
      cfg_high   = rls_pkg::RST_HIGH_THRESHOLD;
      cfg_cruise = rls_pkg::RST_CRUISE_SPEED;
      cfg_slow   = rls_pkg::RST_SLOW_SPEED;
      cfg_pivot  = rls_pkg::RST_PIVOT_SPEED;
      poll_count = '0;
      for (int c = 0; c < rls_pkg::RULE_CHANNELS; c++)
         first_low[c] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default settings, then cut the window below the current count
      queue_poll(8'h00);
      queue_poll(8'hFF);
      queue_poll(8'hA5);
      wait_idle();
      csr_write(rls_pkg::REG_WINDOW_LENGTH, 14'd2);
      csr_valid <= 1'b0;
      queue_poll(8'h3C);
      wait_idle();

      // two-poll windows: the first poll discharges everything at index zero,
      // which must not count, the second one picks the channel
      csr_write(rls_pkg::REG_LOW_THRESHOLD, 14'd0);
      csr_write(rls_pkg::REG_HIGH_THRESHOLD, 14'd2);
      csr_valid <= 1'b0;
      foreach (pivot_polls[i]) begin
         queue_poll(8'h00);
         queue_poll(pivot_polls[i]);
      end
      wait_idle();
      csr_write(rls_pkg::REG_SECTION_MODE, DATA_BITS'(rls_pkg::MODE_STOP_WHITE));
      csr_write(rls_pkg::REG_LOW_THRESHOLD, 14'd1);
      csr_valid <= 1'b0;
      queue_poll(8'h00);
      queue_poll(8'hFF);
      wait_idle();
      csr_write(rls_pkg::REG_SECTION_MODE, DATA_BITS'(rls_pkg::MODE_LEFT_PIVOT));
      csr_write(rls_pkg::REG_LOW_THRESHOLD, 14'd0);
      csr_valid <= 1'b0;
      queue_poll(8'h00);
      queue_poll(8'h7F);
      wait_idle();
      csr_write(rls_pkg::REG_SECTION_MODE, DATA_BITS'(rls_pkg::MODE_LAP_MARK));
      csr_valid <= 1'b0;
      queue_poll(8'h00);
      queue_poll(8'hE3);
      wait_idle();

      // one-poll windows against a long stall, so the block backs up its input
      csr_write(rls_pkg::REG_WINDOW_LENGTH, 14'd1);
      csr_valid <= 1'b0;
      hold_orders++;
      queue_windowed(60);
      wait_idle();

      // random settings, each followed by a few short windows
      while (random_polls < RANDOM_POLLS) begin
         random_settings();
         span  = (cfg_window == '0) ? 1 : int'(cfg_window);
         count = $urandom_range(1, 6) * span;
         if ($urandom_range(0, 2) == 0) count += $urandom_range(1, span);
         calm = (random_polls >= RANDOM_POLLS - CALM_POLLS);
         queue_windowed(count);
         random_polls += count;
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
